### hdl/pcct_pkg.sv
// ----------------------------------------------------------------------------
// pcct_pkg
// Shared types and constants for the pulse coin credit tracker.
// ----------------------------------------------------------------------------
package pcct_pkg;

    localparam int SLOT_COUNT   = 6;
    localparam int VALUE_WIDTH  = 32;
    localparam int PIN_WIDTH    = 6;
    localparam int CMD_WIDTH    = 2;
    localparam int REG_IDX_WIDTH = 3;
    localparam int SLOT_WIDTH   = 3;

    typedef logic [CMD_WIDTH-1:0]     t_cmd;
    typedef logic [REG_IDX_WIDTH-1:0] t_reg_idx;
    typedef logic [SLOT_WIDTH-1:0]    t_slot;
    typedef logic [PIN_WIDTH-1:0]     t_pins;
    typedef logic [VALUE_WIDTH-1:0]   t_value;

    // commands
    localparam t_cmd CMD_PARALLEL = 2'd0;
    localparam t_cmd CMD_SERIAL   = 2'd1;
    localparam t_cmd CMD_SPEND    = 2'd2;

    // configuration register indexes
    localparam t_reg_idx REG_ACCEPTOR_ENABLE    = 3'd0;
    localparam t_reg_idx REG_ENABLE_ACTIVE_HIGH = 3'd1;
    localparam t_reg_idx REG_COIN_SLOT1         = 3'd2;
    localparam t_reg_idx REG_COIN_SLOT6         = 3'd7;

    localparam t_pins PIN_MASK     = 6'h3F;
    localparam t_pins PIN_SLOT1    = 6'h20;
    localparam t_pins PIN_SLOT6    = 6'h01;

    localparam t_slot SLOT_NONE    = 3'd0;
    localparam t_slot SLOT_LAST    = 3'd6;

    // credit request from the parallel slot tracker
    typedef struct packed {
        logic  add_en;
        t_slot value_idx;   // 0 selects slot 1
    } t_slot_req;

endpackage

### hdl/pcct_if.sv
// ----------------------------------------------------------------------------
// pcct interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface pcct_in_if;
    logic               valid;
    logic               ready;
    pcct_pkg::t_cmd     command;
    pcct_pkg::t_pins    channel_pins;
    logic               serial_pin;
    pcct_pkg::t_value   spend_amount;

    modport source (output valid, command, channel_pins, serial_pin, spend_amount,
                    input ready);
    modport sink   (input valid, command, channel_pins, serial_pin, spend_amount,
                    output ready);
endinterface

interface pcct_out_if;
    logic               valid;
    logic               ready;
    pcct_pkg::t_value   credit;
    pcct_pkg::t_value   shortfall;
    logic               inhibit_level;

    modport source (output valid, credit, shortfall, inhibit_level, input ready);
    modport sink   (input valid, credit, shortfall, inhibit_level, output ready);
endinterface

interface pcct_cfg_if;
    logic                 valid;
    logic                 ready;
    pcct_pkg::t_reg_idx   index;
    pcct_pkg::t_value     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pcct_slot_tracker.sv
// ----------------------------------------------------------------------------
// pcct_slot_tracker
// Debounces the six active-low parallel pins: a slot seen on two samples in
// a row is latched and requested for credit once all pins return high.
// ----------------------------------------------------------------------------
module pcct_slot_tracker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample,
    input  pcct_pkg::t_pins        i_pins,
    output pcct_pkg::t_slot_req    o_req
);

    pcct_pkg::t_slot r_cand;
    pcct_pkg::t_slot n_cand;
    logic            r_latched;
    logic            n_latched;

    pcct_pkg::t_pins w_low;
    pcct_pkg::t_slot w_seen;
    logic            w_all_high;

    function automatic pcct_pkg::t_slot slot_decode(input pcct_pkg::t_pins low);
        pcct_pkg::t_slot s;
        s = pcct_pkg::SLOT_NONE;
        case (low)
            pcct_pkg::PIN_SLOT6: s = 3'd6;
            6'h02:               s = 3'd5;
            6'h04:               s = 3'd4;
            6'h08:               s = 3'd3;
            6'h10:               s = 3'd2;
            pcct_pkg::PIN_SLOT1: s = 3'd1;
            default:             s = pcct_pkg::SLOT_NONE;
        endcase
        return s;
    endfunction

    assign w_low      = ~i_pins & pcct_pkg::PIN_MASK;
    assign w_all_high = (w_low == '0);
    assign w_seen     = w_all_high ? pcct_pkg::SLOT_NONE : slot_decode(w_low);

    always_comb begin
        n_cand        = r_cand;
        n_latched     = r_latched;
        o_req.add_en  = 1'b0;
        o_req.value_idx = 3'(r_cand - 3'd1);
        if (w_all_high) begin
            if (r_latched) begin
                n_latched    = 1'b0;
                o_req.add_en = (r_cand != pcct_pkg::SLOT_NONE) &&
                               (r_cand <= pcct_pkg::SLOT_LAST);
            end
            n_cand = pcct_pkg::SLOT_NONE;
        end
        // a latched slot ignores everything but the release
        if (!n_latched) begin
            if (n_cand != pcct_pkg::SLOT_NONE && n_cand == w_seen) begin
                n_latched = 1'b1;
            end else begin
                n_cand = w_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand    <= pcct_pkg::SLOT_NONE;
            r_latched <= 1'b0;
        end else if (i_sample) begin
            r_cand    <= n_cand;
            r_latched <= n_latched;
        end
    end

    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand <= pcct_pkg::SLOT_LAST)
        else $error("candidate slot out of range");

    a_latched_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |-> r_cand != pcct_pkg::SLOT_NONE)
        else $error("latched without a candidate slot");

    a_credit_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample && o_req.add_en) |=> !r_latched && r_cand == pcct_pkg::SLOT_NONE)
        else $error("credit request did not release the slot");

endmodule

### hdl/pulse_coin_credit_tracker.sv
// A sample word is held in the input register; its result word is held in the result register.
// Throughput: one word per cycle unless stalled; credit is updated in a single pass.
// A stalled result holds the input register; ready follows the output side.
// Reset (synchronous, active low) clears credit, slot tracking, serial edge state
// and all configuration registers to zero.
// ----------------------------------------------------------------------------
// pulse_coin_credit_tracker
// Keeps a saturating credit total fed by parallel and serial coin pulses and
// drained by spend commands; reports credit, shortfall and inhibit drive.
// ----------------------------------------------------------------------------
module pulse_coin_credit_tracker #(
    parameter int CREDIT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pcct_in_if.sink          i_in,
    pcct_out_if.source       o_out,
    pcct_cfg_if.sink         i_cfg
);

    localparam int SUM_WIDTH = ((CREDIT_WIDTH > pcct_pkg::VALUE_WIDTH) ?
                                CREDIT_WIDTH : pcct_pkg::VALUE_WIDTH) + 1;
    localparam logic [CREDIT_WIDTH-1:0] CREDIT_MAX = {CREDIT_WIDTH{1'b1}};

    // configuration
    logic               r_acceptor_enable;
    logic               r_enable_active_high;
    pcct_pkg::t_value   r_coin_value [pcct_pkg::SLOT_COUNT];

    // input register
    logic               r_in_valid;
    pcct_pkg::t_cmd     r_cmd;
    pcct_pkg::t_pins    r_pins;
    logic               r_serial_pin;
    pcct_pkg::t_value   r_spend_amount;

    // state
    logic [CREDIT_WIDTH-1:0] r_credit;
    logic [CREDIT_WIDTH-1:0] n_credit;
    logic               r_serial_prev_high;
    logic               n_serial_prev_high;

    // result register
    logic               r_out_valid;
    pcct_pkg::t_value   r_out_credit;
    pcct_pkg::t_value   r_out_shortfall;
    logic               r_out_inhibit;
    logic [SUM_WIDTH-1:0] n_missing;

    logic               w_advance;
    logic               w_exec;
    logic               w_par_sample;
    pcct_pkg::t_slot_req w_req;
    logic               w_add_en;
    pcct_pkg::t_value   w_add_val;
    logic [SUM_WIDTH-1:0] w_credit_ext;
    logic [SUM_WIDTH-1:0] w_amount_ext;
    logic [SUM_WIDTH-1:0] w_sum;
    logic [SUM_WIDTH-1:0] w_rem;

    assign w_advance    = !r_out_valid || o_out.ready;
    assign i_in.ready   = !r_in_valid || w_advance;
    assign w_exec       = r_in_valid && w_advance;
    assign w_par_sample = w_exec && (r_cmd == pcct_pkg::CMD_PARALLEL);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acceptor_enable    <= 1'b0;
            r_enable_active_high <= 1'b0;
            for (int i = 0; i < pcct_pkg::SLOT_COUNT; i++) begin
                r_coin_value[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == pcct_pkg::REG_ACCEPTOR_ENABLE) begin
                r_acceptor_enable <= i_cfg.data[0];
            end else if (i_cfg.index == pcct_pkg::REG_ENABLE_ACTIVE_HIGH) begin
                r_enable_active_high <= i_cfg.data[0];
            end else if (i_cfg.index inside
                         {[pcct_pkg::REG_COIN_SLOT1:pcct_pkg::REG_COIN_SLOT6]}) begin
                r_coin_value[pcct_pkg::SLOT_WIDTH'(i_cfg.index -
                             pcct_pkg::REG_COIN_SLOT1)] <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd          <= i_in.command;
            r_pins         <= i_in.channel_pins;
            r_serial_pin   <= i_in.serial_pin;
            r_spend_amount <= i_in.spend_amount;
        end
    end

    pcct_slot_tracker u_slot_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (w_par_sample),
        .i_pins   (r_pins),
        .o_req    (w_req)
    );

    assign w_credit_ext = SUM_WIDTH'(r_credit);
    assign w_amount_ext = SUM_WIDTH'(r_spend_amount);
    assign w_sum        = w_credit_ext + SUM_WIDTH'(w_add_val);
    assign w_rem        = w_credit_ext - w_amount_ext;

    always_comb begin
        w_add_en           = 1'b0;
        w_add_val          = r_coin_value[w_req.value_idx];
        n_serial_prev_high = r_serial_prev_high;
        n_credit           = r_credit;
        n_missing          = '0;
        case (r_cmd)
            pcct_pkg::CMD_PARALLEL: begin
                w_add_en = w_req.add_en;
            end
            pcct_pkg::CMD_SERIAL: begin
                // falling edge of the serial pin credits slot 1
                w_add_val          = r_coin_value[0];
                w_add_en           = !r_serial_pin && r_serial_prev_high;
                n_serial_prev_high = r_serial_pin;
            end
            pcct_pkg::CMD_SPEND: begin
                if (w_amount_ext <= w_credit_ext) begin
                    n_credit = w_rem[CREDIT_WIDTH-1:0];
                end else begin
                    n_credit  = '0;
                    n_missing = w_amount_ext - w_credit_ext;
                end
            end
            default: begin
            end
        endcase
        if (w_add_en) begin
            n_credit = (w_sum > SUM_WIDTH'(CREDIT_MAX)) ? CREDIT_MAX
                                                        : w_sum[CREDIT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit           <= '0;
            r_serial_prev_high <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_exec) begin
                r_credit           <= n_credit;
                r_serial_prev_high <= n_serial_prev_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_credit    <= pcct_pkg::VALUE_WIDTH'(SUM_WIDTH'(n_credit));
            r_out_shortfall <= n_missing[pcct_pkg::VALUE_WIDTH-1:0];
            r_out_inhibit   <= (r_acceptor_enable == r_enable_active_high);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.credit        = r_out_credit;
    assign o_out.shortfall     = r_out_shortfall;
    assign o_out.inhibit_level = r_out_inhibit;

    a_shortfall_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.shortfall != '0) |-> o_out.credit == '0)
        else $error("shortfall reported with credit left");

    a_in_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid && $stable(r_cmd))
        else $error("input word lost while output stalled");

    a_credit_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> $stable(r_credit))
        else $error("credit changed without a word");

endmodule
